// ===== hdl/pcmrv_pkg.sv =====
// ----------------------------------------------------------------------------
// pcmrv_pkg
// Shared constants, command and mode codes, and the pipeline status struct
// for the PCM ring volume player.
// ----------------------------------------------------------------------------
package pcmrv_pkg;

    // Ring geometry (power of two: pointers wrap by truncation)
    localparam int RING_DEPTH = 8192;
    localparam int ADDR_W     = $clog2(RING_DEPTH);

    // Field widths
    localparam int CMD_W    = 3;
    localparam int SAMPLE_W = 16;
    localparam int VOL_W    = 7;
    localparam int MODE_W   = 2;
    localparam int FILL_W   = 13;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_FEED  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PLAY  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PAUSE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STOP  = 3'd4;

    // Play mode codes
    localparam logic [MODE_W-1:0] MODE_STOPPED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PLAYING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PAUSED  = 2'd2;

    // Volume register
    localparam logic [VOL_W-1:0] VOLUME_MAX   = 7'd100;
    localparam logic [VOL_W-1:0] VOLUME_RESET = 7'd80;

    // Scaling arithmetic: |sample * volume| < 2^22, divided by 100 through
    // a reciprocal estimate (10486 / 2^20) that is exact or one too high.
    localparam int PROD_W      = SAMPLE_W + VOL_W + 1;
    localparam int MAG_W       = 22;
    localparam int RECIP_W     = 14;
    localparam int RECIP_SHIFT = 20;
    localparam logic [RECIP_W-1:0] RECIP_MULT = 14'd10486;
    localparam int EST_W       = MAG_W + RECIP_W;
    localparam int QUOT_W      = 16;
    localparam int CHECK_W     = QUOT_W + VOL_W;
    localparam logic [VOL_W-1:0] DIVISOR = 7'd100;

    // Status that travels with each transaction down the pipeline
    typedef struct packed {
        logic              live;
        logic              popped;
        logic              accepted;
        logic [MODE_W-1:0] mode;
        logic [FILL_W-1:0] fill;
    } meta_t;

endpackage

// ===== hdl/pcmrv_scale.sv =====
// ----------------------------------------------------------------------------
// pcmrv_scale
// Volume scaling pipeline: multiply by volume, divide by 100 toward zero,
// and hold the finished result in the output register.
// ----------------------------------------------------------------------------
module pcmrv_scale import pcmrv_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       advance,
    input  meta_t                      meta_in,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic [VOL_W-1:0]           volume,
    output meta_t                      meta_out,
    output logic signed [SAMPLE_W-1:0] sample_out
);

    meta_t                     meta2_reg;
    logic signed [PROD_W-1:0]  prod2_reg;
    meta_t                     meta3_reg;
    logic [MAG_W-1:0]          mag3_reg;
    logic                      neg3_reg;
    logic [QUOT_W-1:0]         quot3_reg;
    meta_t                     meta_out_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;

    logic signed [PROD_W-1:0]  prod2_next;
    logic [PROD_W-1:0]         prod2_abs;
    logic [EST_W-1:0]          est3_full;
    logic [CHECK_W-1:0]        check3;
    logic [QUOT_W-1:0]         quot_fixed;
    logic signed [SAMPLE_W:0]  signed_quot;
    logic signed [SAMPLE_W-1:0] sample_out_next;

    // Stage 2: sample times volume
    assign prod2_next = $signed(PROD_W'(sample_in)) * $signed(PROD_W'({1'b0, volume}));

    // Stage 3: magnitude and reciprocal estimate of the quotient
    assign prod2_abs = prod2_reg[PROD_W-1] ? PROD_W'(-prod2_reg) : PROD_W'(prod2_reg);
    assign est3_full = EST_W'(prod2_abs[MAG_W-1:0]) * EST_W'(RECIP_MULT);

    // Output stage: drop the estimate by one when it overshoots, reapply sign.
    // Volume never exceeds 100, so the quotient always fits 16 bits signed.
    always_comb begin
        check3     = CHECK_W'(quot3_reg) * CHECK_W'(DIVISOR);
        quot_fixed = (check3 > CHECK_W'(mag3_reg)) ? quot3_reg - 1'b1 : quot3_reg;
        signed_quot = neg3_reg ? -$signed({1'b0, quot_fixed})
                               :  $signed({1'b0, quot_fixed});
        sample_out_next = meta3_reg.popped ? signed_quot[SAMPLE_W-1:0] : '0;
    end

    // Pipeline stages; only the stage valid bits are reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meta2_reg.live    <= 1'b0;
            meta3_reg.live    <= 1'b0;
            meta_out_reg.live <= 1'b0;
        end else if (advance) begin
            meta2_reg      <= meta_in;
            prod2_reg      <= prod2_next;

            meta3_reg      <= meta2_reg;
            mag3_reg       <= prod2_abs[MAG_W-1:0];
            neg3_reg       <= prod2_reg[PROD_W-1];
            quot3_reg      <= est3_full[RECIP_SHIFT +: QUOT_W];

            meta_out_reg   <= meta3_reg;
            sample_out_reg <= sample_out_next;
        end
    end

    assign meta_out   = meta_out_reg;
    assign sample_out = sample_out_reg;

endmodule

// ===== hdl/pcm_ring_volume_player_core.sv =====
// ----------------------------------------------------------------------------
// pcm_ring_volume_player_core
// Ring FIFO of signed 16-bit PCM samples with play / pause / stop control
// and volume scaling of popped samples.
// ----------------------------------------------------------------------------
//  Channel   Ports                                   Direction
//  s_        s_valid s_ready s_cmd s_in_sample       command in
//  m_        m_valid m_ready m_out_valid ...         result out
//  cfg_      cfg_valid cfg_ready cfg_volume          volume register write
//
//  One transaction enters per cycle unless the pipeline holds; its result
//  passes through the registered ring read, then the multiply, reciprocal
//  estimate and correction stages of the scaler, into the output register.
//  While the result register is full and m_ready is low, the whole pipeline
//  holds and s_ready is low. Reset is synchronous; the ring needs no clearing.
// ----------------------------------------------------------------------------
module pcm_ring_volume_player_core import pcmrv_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [CMD_W-1:0]           s_cmd,
    input  logic signed [SAMPLE_W-1:0] s_in_sample,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_out_valid,
    output logic signed [SAMPLE_W-1:0] m_out_sample,
    output logic                       m_accepted,
    output logic [MODE_W-1:0]          m_mode_now,
    output logic [FILL_W-1:0]          m_fill_level,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [VOL_W-1:0]           cfg_volume
);

    logic [SAMPLE_W-1:0]  ring_mem [RING_DEPTH];
    logic [SAMPLE_W-1:0]  rdata_reg;

    logic [ADDR_W-1:0]    wp_reg, wp_next;
    logic [ADDR_W-1:0]    rp_reg, rp_next;
    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic [VOL_W-1:0]     volume_reg;
    meta_t                meta1_reg;

    logic                 advance;
    logic                 in_fire;
    logic [ADDR_W-1:0]    fill_now;
    logic [ADDR_W-1:0]    fill_after;
    logic                 do_push;
    logic                 do_pop;
    meta_t                meta_done;
    logic signed [SAMPLE_W-1:0] sample_done;

    // Pipeline moves whenever the result register is free or being taken
    assign advance   = !meta_done.live || m_ready;
    assign s_ready   = advance;
    assign in_fire   = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign fill_now   = wp_reg - rp_reg;
    assign fill_after = wp_next - rp_next;

    // Command decode and pointer / mode update
    always_comb begin
        wp_next   = wp_reg;
        rp_next   = rp_reg;
        mode_next = mode_reg;
        do_push   = 1'b0;
        do_pop    = 1'b0;
        if (in_fire) begin
            unique case (s_cmd)
                CMD_FEED: begin
                    if (fill_now != ADDR_W'(RING_DEPTH - 1)) begin
                        do_push = 1'b1;
                        wp_next = wp_reg + 1'b1;
                    end
                end
                CMD_TICK: begin
                    if (mode_reg == MODE_PLAYING && fill_now != '0) begin
                        do_pop  = 1'b1;
                        rp_next = rp_reg + 1'b1;
                    end
                end
                CMD_PLAY:  mode_next = MODE_PLAYING;
                CMD_PAUSE: mode_next = MODE_PAUSED;
                CMD_STOP: begin
                    mode_next = MODE_STOPPED;
                    wp_next   = '0;
                    rp_next   = '0;
                end
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg         <= '0;
            rp_reg         <= '0;
            mode_reg       <= MODE_STOPPED;
            volume_reg     <= VOLUME_RESET;
        end else begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            mode_reg <= mode_next;
            if (cfg_valid && cfg_ready) begin
                volume_reg <= (cfg_volume > VOLUME_MAX) ? VOLUME_MAX : cfg_volume;
            end
        end
    end

    // Stage 1 status
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meta1_reg.live <= 1'b0;
        end else if (advance) begin
            meta1_reg <= '{live: in_fire, popped: do_pop, accepted: do_push,
                           mode: mode_next, fill: FILL_W'(fill_after)};
        end
    end

    // Sample ring: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (do_push) begin
            ring_mem[wp_reg] <= s_in_sample;
        end
        if (advance) begin
            rdata_reg <= ring_mem[rp_reg];
        end
    end

    pcmrv_scale u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .meta_in    (meta1_reg),
        .sample_in  ($signed(rdata_reg)),
        .volume     (volume_reg),
        .meta_out   (meta_done),
        .sample_out (sample_done)
    );

    assign m_valid      = meta_done.live;
    assign m_out_valid  = meta_done.popped;
    assign m_out_sample = sample_done;
    assign m_accepted   = meta_done.accepted;
    assign m_mode_now   = meta_done.mode;
    assign m_fill_level = meta_done.fill;

    // Checks
    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_cmd == CMD_FEED && fill_now == ADDR_W'(RING_DEPTH - 1))
        |=> $stable(wp_reg))
        else $error("feed into full ring moved the write pointer");

    a_stop_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_cmd == CMD_STOP) |=> (wp_reg == '0 && rp_reg == '0))
        else $error("stop did not clear the pointers");

    a_no_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_cmd == CMD_TICK && mode_reg != MODE_PLAYING) |=> $stable(rp_reg))
        else $error("tick popped while not playing");

    a_zero_unpopped: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_out_valid) |-> (m_out_sample == '0))
        else $error("nonzero sample on a result without a pop");

    a_pop_push_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_out_valid && m_accepted))
        else $error("result flags both a pop and a push");

endmodule
